// ===== hw/rtl/ogdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ogdc_pkg
// shared widths, constants, codes and types of the orientation to drive
// command pipeline
// ----------------------------------------------------------------------------
package ogdc_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int QW          = 19;
    localparam int PW          = 38;
    localparam int SW          = 32;
    localparam int CW          = 40;
    localparam int ZW          = 24;
    localparam int SQRT_STEPS  = 31;
    localparam int RECIP_K     = 32;
    localparam int MW          = 20;
    localparam int NW          = 29;
    localparam int MAGW        = 14;

    localparam int SIXTY_DEG     = 8579;
    localparam int FIFTEEN_DEG   = 2145;
    localparam int FORTYFIVE_DEG = 6434;

    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [16:0]   HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [PW-1:0] ONE_Q30     = 38'sd1073741824;

    localparam logic signed [15:0] SIXTY_Q13   = 16'(SIXTY_DEG);
    localparam logic signed [15:0] FIFTEEN_Q13 = 16'(FIFTEEN_DEG);

    localparam logic [MAGW-1:0] D60      = MAGW'(SIXTY_DEG);
    localparam logic [MAGW-1:0] D45      = MAGW'(FORTYFIVE_DEG);
    localparam logic [NW-1:0]   D60_HALF = NW'(SIXTY_DEG / 2);
    localparam logic [NW-1:0]   D45_HALF = NW'(FORTYFIVE_DEG / 2);
    localparam logic [MW-1:0]   M60      = MW'((64'd1 << RECIP_K) / 64'(SIXTY_DEG));
    localparam logic [MW-1:0]   M45      = MW'((64'd1 << RECIP_K) / 64'(FORTYFIVE_DEG));

    localparam logic [2:0] POSE_REST     = 3'd0;
    localparam logic [2:0] POSE_FIST     = 3'd1;
    localparam logic [2:0] POSE_WAVE_IN  = 3'd2;
    localparam logic [2:0] POSE_WAVE_OUT = 3'd3;
    localparam logic [2:0] POSE_SPREAD   = 3'd4;
    localparam logic [2:0] POSE_UNKNOWN  = 3'd6;

    typedef enum logic [3:0] {
        ACT_IDLE    = 4'd0,
        ACT_FWD     = 4'd1,
        ACT_BACK    = 4'd4,
        ACT_RAISE   = 4'd5,
        ACT_LOWER   = 4'd6,
        ACT_COLLECT = 4'd7,
        ACT_EJECT   = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        REG_W = 2'd0,
        REG_X = 2'd1,
        REG_Y = 2'd2,
        REG_Z = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0] pose;
        logic       active;
    } tag_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [15:0] param;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } result_t;

    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        case (i)
            0:       return 24'sd823550;
            1:       return 24'sd486170;
            2:       return 24'sd256879;
            3:       return 24'sd130396;
            4:       return 24'sd65451;
            5:       return 24'sd32757;
            6:       return 24'sd16383;
            7:       return 24'sd8192;
            8:       return 24'sd4096;
            9:       return 24'sd2048;
            10:      return 24'sd1024;
            11:      return 24'sd512;
            12:      return 24'sd256;
            13:      return 24'sd128;
            14:      return 24'sd64;
            15:      return 24'sd32;
            16:      return 24'sd16;
            17:      return 24'sd8;
            18:      return 24'sd4;
            19:      return 24'sd2;
            20:      return 24'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/orientation_gesture_to_drive_command_core.sv =====
// ----------------------------------------------------------------------------
// orientation_gesture_to_drive_command_core
// relative euler angles of an armband quaternion and the drive command
// chosen from them and the gesture
//
//   channel  dir  handshake               payload
//   s_       in   s_tvalid / s_tready     s_tdata quaternion, s_tuser gesture
//   m_       out  m_tvalid / m_tready     m_tdata param and angles, m_tuser action
//   cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data reference quaternion
//
// one word per cycle in and out, sustained while m_tready keeps the output queue from filling
// most of the pipeline depth lies in the square root and cordic stages
// all stages advance together; a two-word output queue keeps s_tready high
// while one result waits
// reset clears valid bits and loads the identity reference
// ----------------------------------------------------------------------------
module orientation_gesture_to_drive_command_core
    import ogdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  logic [4:0]  s_tuser,   // pose[2:0], on_arm, unlocked
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // param, roll, pitch[14:0], yaw, pad
    output logic [3:0]  m_tuser,   // action
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic signed [15:0] ref_w_reg, ref_x_reg, ref_y_reg, ref_z_reg;

    logic                 en;
    tag_t                 in_tag, q_tag, e_tag, c_tag;
    logic                 q_vld, e_vld, c_vld, d_vld;
    logic signed [QW-1:0] w, x, y, z;
    logic signed [PW-1:0] roll_y, roll_x, yaw_y, yaw_x;
    logic signed [SW-1:0] pit_y, pit_x;
    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
    result_t              d_res, out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_w_reg <= 16'sd32767;
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_W: ref_w_reg <= $signed(cfg_data);
                REG_X: ref_x_reg <= $signed(cfg_data);
                REG_Y: ref_y_reg <= $signed(cfg_data);
                REG_Z: ref_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign s_tready      = en;
    assign in_tag.pose   = s_tuser[2:0];
    assign in_tag.active = s_tuser[3] & s_tuser[4];

    ogdc_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_tag  (in_tag),
        .qw      ($signed(s_tdata[15:0])),
        .qx      ($signed(s_tdata[31:16])),
        .qy      ($signed(s_tdata[47:32])),
        .qz      ($signed(s_tdata[63:48])),
        .rw      (ref_w_reg),
        .rx      (ref_x_reg),
        .ry      (ref_y_reg),
        .rz      (ref_z_reg),
        .out_vld (q_vld),
        .out_tag (q_tag),
        .w       (w),
        .x       (x),
        .y       (y),
        .z       (z)
    );

    ogdc_euler u_euler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (q_vld),
        .in_tag  (q_tag),
        .w       (w),
        .x       (x),
        .y       (y),
        .z       (z),
        .out_vld (e_vld),
        .out_tag (e_tag),
        .roll_y  (roll_y),
        .roll_x  (roll_x),
        .pit_y   (pit_y),
        .pit_x   (pit_x),
        .yaw_y   (yaw_y),
        .yaw_x   (yaw_x)
    );

    ogdc_cordic u_cordic_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (e_vld),
        .in_tag  (e_tag),
        .y       (CW'(roll_y)),
        .x       (CW'(roll_x)),
        .out_vld (c_vld),
        .out_tag (c_tag),
        .angle   (roll_z)
    );

    ogdc_cordic u_cordic_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (e_vld),
        .in_tag  ('0),
        .y       (CW'(pit_y)),
        .x       (CW'(pit_x)),
        .out_vld (),
        .out_tag (),
        .angle   (pitch_z)
    );

    ogdc_cordic u_cordic_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (e_vld),
        .in_tag  ('0),
        .y       (CW'(yaw_y)),
        .x       (CW'(yaw_x)),
        .out_vld (),
        .out_tag (),
        .angle   (yaw_z)
    );

    ogdc_decide u_decide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (c_vld),
        .in_tag  (c_tag),
        .roll_z  (roll_z),
        .pitch_z (pitch_z),
        .yaw_z   (yaw_z),
        .out_vld (d_vld),
        .res     (d_res)
    );

    ogdc_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (d_vld && en),
        .din     (d_res),
        .room    (en),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .dout    (out_res)
    );

    assign m_tuser = out_res.action;
    assign m_tdata = {1'b0, out_res.yaw, out_res.pitch, out_res.roll, out_res.param};

endmodule

// ===== hw/rtl/ogdc_qmul.sv =====
// ----------------------------------------------------------------------------
// ogdc_qmul
// product of the measured quaternion and the conjugate reference, rounded
// back to q.15 over two stages
// ----------------------------------------------------------------------------
module ogdc_qmul
    import ogdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  tag_t                 in_tag,
    input  logic signed [15:0]   qw,
    input  logic signed [15:0]   qx,
    input  logic signed [15:0]   qy,
    input  logic signed [15:0]   qz,
    input  logic signed [15:0]   rw,
    input  logic signed [15:0]   rx,
    input  logic signed [15:0]   ry,
    input  logic signed [15:0]   rz,
    output logic                 out_vld,
    output tag_t                 out_tag,
    output logic signed [QW-1:0] w,
    output logic signed [QW-1:0] x,
    output logic signed [QW-1:0] y,
    output logic signed [QW-1:0] z
);

    logic signed [31:0]   p_reg [16];
    logic                 vld1_reg, vld2_reg;
    tag_t                 tag1_reg, tag2_reg;
    logic signed [QW-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [34:0]   sw_next, sx_next, sy_next, sz_next;

    function automatic logic signed [QW-1:0] rnd15(input logic signed [34:0] s);
        logic signed [34:0] t;
        t = s + 35'sd16384;
        return t[15 +: QW];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]  <= qw * rw;
            p_reg[1]  <= qx * rx;
            p_reg[2]  <= qy * ry;
            p_reg[3]  <= qz * rz;
            p_reg[4]  <= qw * rx;
            p_reg[5]  <= qx * rw;
            p_reg[6]  <= qy * rz;
            p_reg[7]  <= qz * ry;
            p_reg[8]  <= qw * ry;
            p_reg[9]  <= qx * rz;
            p_reg[10] <= qy * rw;
            p_reg[11] <= qz * rx;
            p_reg[12] <= qw * rz;
            p_reg[13] <= qx * ry;
            p_reg[14] <= qy * rx;
            p_reg[15] <= qz * rw;
            tag1_reg  <= in_tag;
        end
    end

    always_comb begin
        sw_next =  35'(p_reg[0])  + 35'(p_reg[1])  + 35'(p_reg[2])  + 35'(p_reg[3]);
        sx_next = -35'(p_reg[4])  + 35'(p_reg[5])  - 35'(p_reg[6])  + 35'(p_reg[7]);
        sy_next = -35'(p_reg[8])  + 35'(p_reg[9])  + 35'(p_reg[10]) - 35'(p_reg[11]);
        sz_next = -35'(p_reg[12]) - 35'(p_reg[13]) + 35'(p_reg[14]) + 35'(p_reg[15]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg    <= rnd15(sw_next);
            x_reg    <= rnd15(sx_next);
            y_reg    <= rnd15(sy_next);
            z_reg    <= rnd15(sz_next);
            tag2_reg <= tag1_reg;
        end
    end

    assign out_vld = vld2_reg;
    assign out_tag = tag2_reg;
    assign w       = w_reg;
    assign x       = x_reg;
    assign y       = y_reg;
    assign z       = z_reg;

endmodule

// ===== hw/rtl/ogdc_euler.sv =====
// ----------------------------------------------------------------------------
// ogdc_euler
// atan2 operands for roll, pitch and yaw; the pitch cosine term comes from
// a pipelined bit-per-stage square root
// ----------------------------------------------------------------------------
module ogdc_euler
    import ogdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  tag_t                 in_tag,
    input  logic signed [QW-1:0] w,
    input  logic signed [QW-1:0] x,
    input  logic signed [QW-1:0] y,
    input  logic signed [QW-1:0] z,
    output logic                 out_vld,
    output tag_t                 out_tag,
    output logic signed [PW-1:0] roll_y,
    output logic signed [PW-1:0] roll_x,
    output logic signed [SW-1:0] pit_y,
    output logic signed [SW-1:0] pit_x,
    output logic signed [PW-1:0] yaw_y,
    output logic signed [PW-1:0] yaw_x
);

    typedef struct packed {
        tag_t                 tag;
        logic signed [PW-1:0] ry;
        logic signed [PW-1:0] rx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] yx;
        logic signed [SW-1:0] s;
    } side_t;

    localparam logic [61:0] RAD_ONE = 62'd1 << 60;

    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, zz_reg;
    logic                 vld1_reg, vld2_reg;
    tag_t                 tag1_reg;
    side_t                op_reg;
    side_t                side_reg [SQRT_STEPS+1];
    logic                 dvld_reg [SQRT_STEPS+1];
    logic signed [63:0]   sq_reg;
    logic [61:0]          sv_reg [SQRT_STEPS];
    logic [61:0]          sr_reg [SQRT_STEPS];
    logic [61:0]          rad;
    logic signed [PW-1:0] s_raw;
    side_t                op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            dvld_reg[0] <= 1'b0;
        end else if (en) begin
            vld1_reg    <= in_vld;
            vld2_reg    <= vld1_reg;
            dvld_reg[0] <= vld2_reg;
        end
    end

    // products of the relative quaternion
    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg   <= w * x;
            yz_reg   <= y * z;
            xx_reg   <= x * x;
            yy_reg   <= y * y;
            wy_reg   <= w * y;
            zx_reg   <= z * x;
            wz_reg   <= w * z;
            xy_reg   <= x * y;
            zz_reg   <= z * z;
            tag1_reg <= in_tag;
        end
    end

    always_comb begin
        s_raw      = (wy_reg - zx_reg) <<< 1;
        op_next.tag = tag1_reg;
        op_next.ry = (wx_reg + yz_reg) <<< 1;
        op_next.rx = ONE_Q30 - ((xx_reg + yy_reg) <<< 1);
        op_next.yy = (wz_reg + xy_reg) <<< 1;
        op_next.yx = ONE_Q30 - ((yy_reg + zz_reg) <<< 1);
        if (s_raw > ONE_Q30) begin
            op_next.s = SW'(ONE_Q30);
        end else if (s_raw < -ONE_Q30) begin
            op_next.s = SW'(-ONE_Q30);
        end else begin
            op_next.s = SW'(s_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg      <= op_next;
            sq_reg      <= op_reg.s * op_reg.s;
            side_reg[0] <= op_reg;
        end
    end

    assign rad = RAD_ONE - 62'(sq_reg);

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0] v_in, r_in, trial;

        if (k == 0) begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = sv_reg[k-1];
            assign r_in = sr_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (v_in >= trial) begin
                    sv_reg[k] <= v_in - trial;
                    sr_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    sv_reg[k] <= v_in;
                    sr_reg[k] <= r_in >> 1;
                end
                side_reg[k+1] <= side_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end
    end

    assign out_vld = dvld_reg[SQRT_STEPS];
    assign out_tag = side_reg[SQRT_STEPS].tag;
    assign roll_y  = side_reg[SQRT_STEPS].ry;
    assign roll_x  = side_reg[SQRT_STEPS].rx;
    assign yaw_y   = side_reg[SQRT_STEPS].yy;
    assign yaw_x   = side_reg[SQRT_STEPS].yx;
    assign pit_y   = side_reg[SQRT_STEPS].s;
    assign pit_x   = $signed(sr_reg[SQRT_STEPS-1][SW-1:0]);

endmodule

// ===== hw/rtl/ogdc_cordic.sv =====
// ----------------------------------------------------------------------------
// ogdc_cordic
// vectoring cordic atan2, quarter-turn prerotation then one micro-rotation
// per stage, angle in q.20
// ----------------------------------------------------------------------------
module ogdc_cordic
    import ogdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  tag_t                 in_tag,
    input  logic signed [CW-1:0] y,
    input  logic signed [CW-1:0] x,
    output logic                 out_vld,
    output tag_t                 out_tag,
    output logic signed [ZW-1:0] angle
);

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STAGES+1];
    logic                 zero_reg [CORDIC_STAGES+1];
    tag_t                 tag_reg [CORDIC_STAGES+1];
    logic                 vld_reg [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    // prerotation into the right half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x == '0) && (y == '0);
            tag_reg[0]  <= in_tag;
            if (x < 0) begin
                if (y >= 0) begin
                    x_reg[0] <= y;
                    y_reg[0] <= -x;
                    z_reg[0] <= HALF_PI_Q20;
                end else begin
                    x_reg[0] <= -y;
                    y_reg[0] <= x;
                    z_reg[0] <= -HALF_PI_Q20;
                end
            end else begin
                x_reg[0] <= x;
                y_reg[0] <= y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = atan_q20(i);
        logic signed [CW-1:0] dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                zero_reg[i+1] <= zero_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STAGES];
    assign out_tag = tag_reg[CORDIC_STAGES];
    assign angle   = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

endmodule

// ===== hw/rtl/ogdc_decide.sv =====
// ----------------------------------------------------------------------------
// ogdc_decide
// angle rounding to q2.13 (pitch to q1.13), action choice and strength
// scaling by a constant reciprocal with one correction step
// ----------------------------------------------------------------------------
module ogdc_decide
    import ogdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  tag_t                 in_tag,
    input  logic signed [ZW-1:0] roll_z,
    input  logic signed [ZW-1:0] pitch_z,
    input  logic signed [ZW-1:0] yaw_z,
    output logic                 out_vld,
    output result_t              res
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } ang_t;

    logic [4:0]            vld_reg;
    ang_t                  ang1_reg, ang2_reg, ang3_reg, ang4_reg;
    tag_t                  tag1_reg;
    action_t               act2_reg, act3_reg, act4_reg;
    logic                  neg2_reg, neg3_reg, neg4_reg;
    logic [MAGW-1:0]       mag2_reg;
    logic                  dsel2_reg, dsel3_reg;
    logic [NW-1:0]         n3_reg;
    logic [NW+MW-1:0]      prod3_reg;
    logic [16:0]           q4_reg;
    result_t               res_reg;

    action_t               act_next;
    logic                  neg_next, dsel_next;
    logic [MAGW-1:0]       mag_next;
    logic signed [15:0]    rc, pc, pe;
    logic [NW-1:0]         n_next;
    logic [16:0]           q0;
    logic [MAGW-1:0]       dv;
    logic [29:0]           qd, rem;
    logic signed [17:0]    qs;

    function automatic logic signed [16:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [16:0] lim);
        logic signed [ZW-1:0] t;
        logic signed [16:0]   r;
        t = a + ZW'(64);
        r = t[7 +: 17];
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang1_reg.roll  <= 16'(to_q13(roll_z, PI_Q13));
            ang1_reg.pitch <= 15'(to_q13(pitch_z, HALF_PI_Q13));
            ang1_reg.yaw   <= 16'(to_q13(yaw_z, PI_Q13));
            tag1_reg       <= in_tag;
        end
    end

    always_comb begin
        act_next  = ACT_IDLE;
        neg_next  = 1'b0;
        dsel_next = 1'b0;
        mag_next  = '0;
        pe        = 16'(ang1_reg.pitch);
        if (ang1_reg.roll > SIXTY_Q13) begin
            rc = SIXTY_Q13;
        end else if (ang1_reg.roll < -SIXTY_Q13) begin
            rc = -SIXTY_Q13;
        end else begin
            rc = ang1_reg.roll;
        end
        if (pe > SIXTY_Q13) begin
            pc = SIXTY_Q13;
        end else if (pe < -SIXTY_Q13) begin
            pc = -SIXTY_Q13;
        end else begin
            pc = pe;
        end
        if (tag1_reg.active) begin
            case (tag1_reg.pose) inside
                POSE_FIST, POSE_SPREAD: begin
                    act_next = (tag1_reg.pose == POSE_FIST) ? ACT_FWD : ACT_BACK;
                    neg_next = rc < 0;
                    mag_next = (rc < 0) ? MAGW'(-rc) : MAGW'(rc);
                end
                POSE_WAVE_IN: begin
                    act_next = ACT_COLLECT;
                end
                POSE_WAVE_OUT: begin
                    act_next = ACT_EJECT;
                end
                POSE_REST, POSE_UNKNOWN: begin
                    if (pc >= FIFTEEN_Q13) begin
                        act_next  = ACT_RAISE;
                        dsel_next = 1'b1;
                        mag_next  = MAGW'(pc - FIFTEEN_Q13);
                    end else if (pc <= -FIFTEEN_Q13) begin
                        act_next  = ACT_LOWER;
                        dsel_next = 1'b1;
                        neg_next  = 1'b1;
                        mag_next  = MAGW'(-(pc + FIFTEEN_Q13));
                    end
                end
                default: begin
                    act_next = ACT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg  <= act_next;
            neg2_reg  <= neg_next;
            dsel2_reg <= dsel_next;
            mag2_reg  <= mag_next;
            ang2_reg  <= ang1_reg;
        end
    end

    // quotient estimate through the reciprocal of the divisor
    assign n_next = {mag2_reg, 15'd0} + (dsel2_reg ? D45_HALF : D60_HALF);

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg    <= n_next;
            prod3_reg <= n_next * (dsel2_reg ? M45 : M60);
            dsel3_reg <= dsel2_reg;
            act3_reg  <= act2_reg;
            neg3_reg  <= neg2_reg;
            ang3_reg  <= ang2_reg;
        end
    end

    always_comb begin
        q0  = prod3_reg[RECIP_K +: 17];
        dv  = dsel3_reg ? D45 : D60;
        qd  = 30'(q0) * 30'(dv);
        rem = 30'(n3_reg) - qd;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q4_reg   <= q0 + 17'(rem >= 30'(dv));
            act4_reg <= act3_reg;
            neg4_reg <= neg3_reg;
            ang4_reg <= ang3_reg;
        end
    end

    assign qs = $signed({1'b0, q4_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.action <= act4_reg;
            res_reg.roll   <= ang4_reg.roll;
            res_reg.pitch  <= ang4_reg.pitch;
            res_reg.yaw    <= ang4_reg.yaw;
            if (neg4_reg) begin
                res_reg.param <= 16'(-qs);
            end else if (q4_reg[15] || q4_reg[16]) begin
                res_reg.param <= 16'sd32767;
            end else begin
                res_reg.param <= $signed(q4_reg[15:0]);
            end
        end
    end

    assign out_vld = vld_reg[4];
    assign res     = res_reg;

endmodule

// ===== hw/rtl/ogdc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ogdc_out_fifo
// two-word output queue; decouples the result handshake from the pipeline
// advance
// ----------------------------------------------------------------------------
module ogdc_out_fifo
    import ogdc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t din,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t dout
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = cnt_reg != 2'd0;
    assign room    = (cnt_reg != 2'd2) || m_ready;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output queue overfilled");

    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");

    a_cnt_down: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pop lost");

endmodule
